[src/ttlab_pkg.sv]
// Package for the streaming text-to-long converter: the per-unit record that
// passes from the front end to the back end, scan phases and character codes.
// No dependencies.
`default_nettype none

package ttlab_pkg;

  localparam int unsigned MaxStringUnitsDefault = 65535;
  localparam int unsigned QueueDepth = 2;

  localparam int unsigned CuW    = 16;
  localparam int unsigned CountW = 16;
  localparam int unsigned RadixW = 6;
  localparam int unsigned DigW   = 6;
  localparam int unsigned ValW   = 64;
  localparam int unsigned ProdW  = ValW + RadixW;

  localparam logic [RadixW-1:0] RadixReset = 6'd10;
  localparam logic [RadixW-1:0] RadixAuto  = 6'd0;
  localparam logic [RadixW-1:0] BaseOct    = 6'd8;
  localparam logic [RadixW-1:0] BaseDec    = 6'd10;
  localparam logic [RadixW-1:0] BaseHex    = 6'd16;

  localparam logic [CuW-1:0] ChSpace = 16'h0020;
  localparam logic [CuW-1:0] ChTab   = 16'h0009;
  localparam logic [CuW-1:0] ChCr    = 16'h000D;
  localparam logic [CuW-1:0] ChPlus  = 16'h002B;
  localparam logic [CuW-1:0] ChMinus = 16'h002D;
  localparam logic [CuW-1:0] ChZero  = 16'h0030;
  localparam logic [CuW-1:0] ChNine  = 16'h0039;
  localparam logic [CuW-1:0] ChLowA  = 16'h0061;
  localparam logic [CuW-1:0] ChLowZ  = 16'h007A;
  localparam logic [CuW-1:0] ChUpA   = 16'h0041;
  localparam logic [CuW-1:0] ChUpZ   = 16'h005A;
  localparam logic [CuW-1:0] ChLowX  = 16'h0078;
  localparam logic [CuW-1:0] ChUpX   = 16'h0058;

  localparam logic [ValW-1:0] LongMax = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [ValW-1:0] LongMin = 64'h8000_0000_0000_0000;

  typedef enum logic [4:0] {
    PH_LEAD   = 5'b00001,
    PH_START  = 5'b00010,
    PH_ZERO   = 5'b00100,
    PH_DIGITS = 5'b01000,
    PH_DONE   = 5'b10000
  } phase_e;

  // One classified code unit.
  typedef struct packed {
    logic              is_space;
    logic              is_sign;
    logic              is_minus;
    logic              is_zero;
    logic              is_x;
    logic              dig_ok;
    logic [DigW-1:0]   dig;
    logic [CountW-1:0] end_pos;
    logic              last;
  } unit_t;

  function automatic logic [DigW:0] digit_of(input logic [CuW-1:0] c);
    logic [CuW-1:0] t;
    begin
      t = '0;
      if (c >= ChZero && c <= ChNine) begin
        t = c - ChZero;
        digit_of = {1'b1, t[DigW-1:0]};
      end else if (c >= ChLowA && c <= ChLowZ) begin
        t = c - ChLowA + 16'd10;
        digit_of = {1'b1, t[DigW-1:0]};
      end else if (c >= ChUpA && c <= ChUpZ) begin
        t = c - ChUpA + 16'd10;
        digit_of = {1'b1, t[DigW-1:0]};
      end else begin
        digit_of = '0;
      end
    end
  endfunction

endpackage

`default_nettype wire

[src/ttlab_front.sv]
// Front end: tracks the position inside the current string and classifies
// each accepted code unit. Depends on ttlab_pkg.
`default_nettype none

module ttlab_front import ttlab_pkg::*; #(
  parameter int unsigned MAX_STRING_UNITS = MaxStringUnitsDefault
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           accept_i,
  input  wire logic [CuW-1:0] code_unit_i,
  input  wire logic           last_unit_i,
  output unit_t               unit_o
);

  localparam int unsigned PosW = $clog2(MAX_STRING_UNITS + 1);
  localparam logic [PosW-1:0] PosMax = PosW'(MAX_STRING_UNITS);

  logic [PosW-1:0] pos_q, pos_d;
  logic [PosW:0]   pos_inc;
  logic            term;
  logic [CuW-1:0]  c;
  logic [DigW:0]   d;

  assign term    = (pos_q >= PosMax);
  assign pos_inc = {1'b0, pos_q} + 1'b1;
  // Units past the length limit behave as a terminator.
  assign c       = term ? '0 : code_unit_i;
  assign d       = digit_of(c);

  always_comb begin
    unit_o.is_space = (c == ChSpace) || (c >= ChTab && c <= ChCr);
    unit_o.is_sign  = (c == ChPlus) || (c == ChMinus);
    unit_o.is_minus = (c == ChMinus);
    unit_o.is_zero  = (c == ChZero);
    unit_o.is_x     = (c == ChLowX) || (c == ChUpX);
    unit_o.dig_ok   = d[DigW];
    unit_o.dig      = d[DigW-1:0];
    unit_o.end_pos  = CountW'(pos_inc);
    unit_o.last     = last_unit_i;
  end

  always_comb begin
    pos_d = pos_q;
    if (accept_i) begin
      if (last_unit_i) begin
        pos_d = '0;
      end else if (!term) begin
        pos_d = pos_inc[PosW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

`default_nettype wire

[src/ttlab_queue.sv]
// Short queue of classified units between the front end and the back end.
// Depends on ttlab_pkg.
`default_nettype none

module ttlab_queue import ttlab_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  wr_i,
  input  wire unit_t wdata_i,
  output logic       full_o,
  input  wire logic  rd_i,
  output unit_t      rdata_o,
  output logic       empty_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QueueDepth - 1);

  unit_t           mem_q [QueueDepth];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_wr, do_rd;

  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_wr) begin
      wptr_d = (wptr_q == PtrLast) ? '0 : wptr_q + 1'b1;
    end
    if (do_rd) begin
      rptr_d = (rptr_q == PtrLast) ? '0 : rptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

`default_nettype wire

[src/ttlab_back.sv]
// Back end: scan state machine, digit accumulator with overflow check, and
// the result register with final saturation. Depends on ttlab_pkg.
`default_nettype none

module ttlab_back import ttlab_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [RadixW-1:0] radix_i,
  input  wire unit_t             unit_i,
  input  wire logic              unit_avail_i,
  output logic                   unit_take_o,
  output logic                   res_valid_o,
  input  wire logic              res_take_i,
  output logic signed [ValW-1:0] value_o,
  output logic [CountW-1:0]      consumed_count_o,
  output logic                   no_digits_o
);

  phase_e              phase_q, phase_d;
  logic                neg_q, neg_d;
  logic [RadixW-1:0]   base_q, base_d;
  logic [ValW-1:0]     mag_q, mag_d;
  logic                ovf_q, ovf_d;
  logic [CountW-1:0]   end_q, end_d;
  logic                seen_q, seen_d;

  logic                rv_q;
  logic                r_neg_q, r_ovf_q, r_seen_q;
  logic [ValW-1:0]     r_mag_q;
  logic [CountW-1:0]   r_end_q;

  logic [RadixW-1:0]   start_base, mul_base;
  logic                zero_prefix, do_start, do_take, dig_fits;
  logic [ProdW-1:0]    prod;

  assign unit_take_o = unit_avail_i && (!rv_q || res_take_i);

  assign start_base  = (radix_i == RadixAuto) ? BaseDec : radix_i;
  assign zero_prefix = ((radix_i == RadixAuto) || (radix_i == BaseHex)) && unit_i.is_zero;
  assign mul_base    = ((phase_q == PH_ZERO) || (phase_q == PH_DIGITS)) ? base_q : start_base;
  assign dig_fits    = unit_i.dig_ok && (unit_i.dig < mul_base);
  assign prod        = ProdW'(mag_q) * ProdW'(mul_base) + ProdW'(unit_i.dig);

  always_comb begin
    phase_d  = phase_q;
    neg_d    = neg_q;
    base_d   = base_q;
    mag_d    = mag_q;
    ovf_d    = ovf_q;
    end_d    = end_q;
    seen_d   = seen_q;
    do_start = 1'b0;
    do_take  = 1'b0;
    unique case (phase_q)
      PH_LEAD: begin
        if (!unit_i.is_space) begin
          if (unit_i.is_sign) begin
            neg_d   = unit_i.is_minus;
            phase_d = PH_START;
          end else begin
            do_start = 1'b1;
          end
        end
      end
      PH_START: begin
        do_start = 1'b1;
      end
      PH_ZERO: begin
        if (unit_i.is_x) begin
          base_d  = BaseHex;
          seen_d  = 1'b0;
          end_d   = '0;
          phase_d = PH_DIGITS;
        end else begin
          do_take = 1'b1;
        end
      end
      PH_DIGITS: begin
        do_take = 1'b1;
      end
      PH_DONE: begin
      end
      default: begin
      end
    endcase
    if (do_start) begin
      if (zero_prefix) begin
        base_d  = (radix_i == RadixAuto) ? BaseOct : BaseHex;
        seen_d  = 1'b1;
        end_d   = unit_i.end_pos;
        mag_d   = '0;
        phase_d = PH_ZERO;
      end else begin
        base_d  = start_base;
        do_take = 1'b1;
      end
    end
    if (do_take) begin
      if (dig_fits) begin
        if (|prod[ProdW-1:ValW]) begin
          ovf_d = 1'b1;
        end else begin
          mag_d = prod[ValW-1:0];
        end
        seen_d  = 1'b1;
        end_d   = unit_i.end_pos;
        phase_d = PH_DIGITS;
      end else begin
        phase_d = PH_DONE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LEAD;
      neg_q   <= 1'b0;
      base_q  <= '0;
      mag_q   <= '0;
      ovf_q   <= 1'b0;
      end_q   <= '0;
      seen_q  <= 1'b0;
      rv_q    <= 1'b0;
    end else begin
      // A new result replaces the popped one in the same cycle.
      rv_q <= (unit_take_o && unit_i.last) || (rv_q && !res_take_i);
      if (unit_take_o) begin
        if (unit_i.last) begin
          phase_q <= PH_LEAD;
          neg_q   <= 1'b0;
          base_q  <= '0;
          mag_q   <= '0;
          ovf_q   <= 1'b0;
          end_q   <= '0;
          seen_q  <= 1'b0;
        end else begin
          phase_q <= phase_d;
          neg_q   <= neg_d;
          base_q  <= base_d;
          mag_q   <= mag_d;
          ovf_q   <= ovf_d;
          end_q   <= end_d;
          seen_q  <= seen_d;
        end
      end
    end
  end

  // Result payload: raw scan outcome, formatted on the way out.
  always_ff @(posedge clk_i) begin
    if (unit_take_o && unit_i.last) begin
      r_neg_q  <= neg_d;
      r_ovf_q  <= ovf_d;
      r_seen_q <= seen_d;
      r_mag_q  <= mag_d;
      r_end_q  <= end_d;
    end
  end

  assign res_valid_o = rv_q;

  always_comb begin
    value_o = '0;
    if (r_seen_q) begin
      if (r_ovf_q) begin
        value_o = r_neg_q ? LongMin : LongMax;
      end else if (r_neg_q) begin
        value_o = (r_mag_q > LongMin) ? LongMin : (~r_mag_q + 1'b1);
      end else begin
        value_o = (r_mag_q > LongMax) ? LongMax : r_mag_q;
      end
    end
    consumed_count_o = r_seen_q ? r_end_q : '0;
    no_digits_o      = !r_seen_q;
  end

endmodule

`default_nettype wire

[src/text_to_long_any_base_unit.sv]
// Top level of the streaming text-to-long converter in any base.
// Instantiates ttlab_front, ttlab_queue and ttlab_back; uses ttlab_pkg.
//
//   Channel   Handshake               Payload
//   input     push / full             code_unit_i, last_unit_i
//   result    empty / pop             value_o, consumed_count_o, no_digits_o
//   config    cfg_we_i                cfg_wdata_i (radix)
//
// One code unit per cycle is sustained while each result is popped as it appears;
// a result shows on the ports once the last unit of its string has passed the
// queue and been taken into the back end's result register. The rate is set by the
// back end's accumulator loop, one 64-by-6-bit multiply-add and overflow check
// per cycle. A two-entry queue decouples the front end from the back end; while
// a result waits to be popped the back end holds, and the input still takes up
// to two more units. full rises only when both the queue and the result
// register are occupied. Reset clears all scan state and sets the radix to ten;
// no clearing pass is needed.
`default_nettype none

module text_to_long_any_base_unit import ttlab_pkg::*; #(
  parameter int unsigned MAX_STRING_UNITS = MaxStringUnitsDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push,
  output logic                   full,
  input  wire logic [CuW-1:0]    code_unit_i,
  input  wire logic              last_unit_i,
  output logic                   empty,
  input  wire logic              pop,
  output logic signed [ValW-1:0] value_o,
  output logic [CountW-1:0]      consumed_count_o,
  output logic                   no_digits_o,
  input  wire logic              cfg_we_i,
  input  wire logic [RadixW-1:0] cfg_wdata_i
);

  logic [RadixW-1:0] radix_q;
  logic              in_accept;
  unit_t             front_unit, q_unit;
  logic              q_empty, q_rd;
  logic              res_valid;

  assign in_accept = push && !full;
  assign empty     = !res_valid;

  // The radix register must be written only while the converter is idle; the block itself does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RadixReset;
    end else if (cfg_we_i) begin
      radix_q <= cfg_wdata_i;
    end
  end

  ttlab_front #(
    .MAX_STRING_UNITS(MAX_STRING_UNITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_accept),
    .code_unit_i (code_unit_i),
    .last_unit_i (last_unit_i),
    .unit_o      (front_unit)
  );

  ttlab_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (push),
    .wdata_i (front_unit),
    .full_o  (full),
    .rd_i    (q_rd),
    .rdata_o (q_unit),
    .empty_o (q_empty)
  );

  ttlab_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .radix_i          (radix_q),
    .unit_i           (q_unit),
    .unit_avail_i     (!q_empty),
    .unit_take_o      (q_rd),
    .res_valid_o      (res_valid),
    .res_take_i       (pop && res_valid),
    .value_o          (value_o),
    .consumed_count_o (consumed_count_o),
    .no_digits_o      (no_digits_o)
  );

endmodule

`default_nettype wire

[src/ttlab_checker.sv]
// Port-level checks for the text-to-long converter, bound to the top level.
// Depends on ttlab_pkg and text_to_long_any_base_unit.
`default_nettype none

module ttlab_checker import ttlab_pkg::*; (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              full,
  input wire logic              empty,
  input wire logic              pop,
  input wire logic signed [ValW-1:0] value_o,
  input wire logic [CountW-1:0] consumed_count_o,
  input wire logic              no_digits_o
);

  // A string without digits reports zero for both value and count.
  a_no_digits_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && no_digits_o) |-> (value_o == '0 && consumed_count_o == '0))
    else $error("no-digit result carries a value or a count");

  // A waiting result that is not popped stays unchanged.
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(value_o) &&
                          $stable(consumed_count_o) && $stable(no_digits_o)))
    else $error("waiting result changed or vanished");

  // While reset is held the converter shows no result and takes input.
  a_reset_state: assert property (@(posedge clk_i)
    !rst_ni |-> (empty && !full))
    else $error("queue flags wrong during reset");

  // Immediately after reset ends no result can be present yet.
  a_no_early_result: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> empty)
    else $error("result present right after reset");

endmodule

bind text_to_long_any_base_unit ttlab_checker u_ttlab_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .full             (full),
  .empty            (empty),
  .pop              (pop),
  .value_o          (value_o),
  .consumed_count_o (consumed_count_o),
  .no_digits_o      (no_digits_o)
);

`default_nettype wire

[tb/tb_text_to_long_any_base_unit.sv]
// Self-checking testbench for text_to_long_any_base_unit, the streaming text-to-long converter.
// It depends on ttlab_pkg and on the DUT, and holds a scoreboard class with its own conversion model.
// Directed strings come first, then random strings under several radix settings.
`timescale 1ns / 100ps

module tb_text_to_long_any_base_unit import ttlab_pkg::*;;

  // The watchdog ends the run after this many cycles in which no transaction happens.
  localparam int unsigned QuietLimit   = 2000;
  // This is the number of random code units to send after the directed strings.
  localparam int unsigned UnitTarget   = 576;
  // A result passes only the queue and the result register, so this settle margin is enough.
  localparam int unsigned SettleCycles = 4;

  typedef struct {
    logic signed [ValW-1:0] value;
    logic [CountW-1:0]      count;
    logic                   no_dig;
  } conv_result_t;

  // The scoreboard keeps its own copy of the scan state and the radix register.
  // It turns each accepted code unit into the conversion result that the end of
  // the string must produce, and it checks the popped results in order.
  class conv_scoreboard;
    logic [RadixW-1:0] radix;
    phase_e            phase;
    bit                negative;
    logic [RadixW-1:0] base;
    logic [ValW-1:0]   magnitude;
    bit                overflowed;
    int unsigned       position;
    int unsigned       end_pos;
    bit                digit_seen;
    conv_result_t      expected_q[$];
    int unsigned       failures;

    function new();
      radix    = RadixReset;
      failures = 0;
      clear_string();
    endfunction

    function void clear_string();
      phase      = PH_LEAD;
      negative   = 1'b0;
      base       = '0;
      magnitude  = '0;
      overflowed = 1'b0;
      position   = 0;
      end_pos    = 0;
      digit_seen = 1'b0;
    endfunction

    // The digit value is 0..35. Any other code unit gives 64, which is never below a base.
    function int unsigned digit_value(logic [CuW-1:0] c);
      if (c >= ChZero && c <= ChNine) return c - ChZero;
      if (c >= ChLowA && c <= ChLowZ) return c - ChLowA + 10;
      if (c >= ChUpA && c <= ChUpZ) return c - ChUpA + 10;
      return 64;
    endfunction

    function bit is_blank(logic [CuW-1:0] c);
      return c == ChSpace || (c >= ChTab && c <= ChCr);
    endfunction

    function void take_digit(logic [CuW-1:0] c, int unsigned pos);
      int unsigned       d;
      logic [RadixW-1:0] b;
      logic [ProdW-1:0]  prod;
      d = digit_value(c);
      b = (base != 0) ? base : 6'd1;
      if (d >= base) begin
        phase = PH_DONE;
        return;
      end
      // The product is 70 bits wide. Any high bit set means the sum passed 2^64-1.
      prod = {{RadixW{1'b0}}, magnitude} * {{ValW{1'b0}}, b} + ProdW'(d);
      if (prod[ProdW-1:ValW] != 0) begin
        overflowed = 1'b1;
      end else begin
        magnitude = prod[ValW-1:0];
      end
      digit_seen = 1'b1;
      end_pos    = pos + 1;
      phase      = PH_DIGITS;
    endfunction

    // This handles the first unit after the whitespace and the optional sign.
    function void begin_number(logic [CuW-1:0] c, int unsigned pos);
      if ((radix == RadixAuto || radix == BaseHex) && c == ChZero) begin
        base       = (radix == RadixAuto) ? BaseOct : BaseHex;
        digit_seen = 1'b1;
        end_pos    = pos + 1;
        magnitude  = '0;
        phase      = PH_ZERO;
      end else begin
        base = (radix == RadixAuto) ? BaseDec : radix;
        take_digit(c, pos);
      end
    endfunction

    function void note_unit(logic [CuW-1:0] cu, logic lst);
      logic [CuW-1:0] c;
      int unsigned    pos;
      conv_result_t   res;
      c   = cu;
      pos = position;
      // A unit that arrives after the length limit acts as a terminator, and position stops there.
      if (pos >= MaxStringUnitsDefault) begin
        c = '0;
      end else begin
        position = pos + 1;
      end
      case (phase)
        PH_LEAD: begin
          if (!is_blank(c)) begin
            if (c == ChPlus || c == ChMinus) begin
              negative = (c == ChMinus);
              phase    = PH_START;
            end else begin
              begin_number(c, pos);
            end
          end
        end
        PH_START: begin
          begin_number(c, pos);
        end
        PH_ZERO: begin
          // A "0x" with no hex digit after it counts as no digits at all.
          if (c == ChLowX || c == ChUpX) begin
            base       = BaseHex;
            digit_seen = 1'b0;
            end_pos    = 0;
            phase      = PH_DIGITS;
          end else begin
            take_digit(c, pos);
          end
        end
        PH_DIGITS: begin
          take_digit(c, pos);
        end
        default: begin
        end
      endcase
      if (!lst) return;
      res.value = '0;
      if (digit_seen) begin
        if (overflowed) begin
          res.value = negative ? LongMin : LongMax;
        end else if (negative) begin
          res.value = (magnitude > LongMin) ? LongMin : -magnitude;
        end else begin
          res.value = (magnitude > LongMax) ? LongMax : magnitude;
        end
      end
      res.count  = digit_seen ? end_pos[CountW-1:0] : '0;
      res.no_dig = !digit_seen;
      expected_q = {expected_q, res};
      clear_string();
    endfunction

    function void check_result(logic signed [ValW-1:0] value, logic [CountW-1:0] count,
                               logic no_dig);
      conv_result_t exp_res;
      if (expected_q.size() == 0) begin
        failures++;
        if (failures <= 10) begin
          $display("ERROR: result with nothing pending: value %0d count %0d no_digits %0b",
                   value, count, no_dig);
        end
        return;
      end
      exp_res = expected_q.pop_front();
      if (value !== exp_res.value || count !== exp_res.count || no_dig !== exp_res.no_dig) begin
        failures++;
        if (failures <= 10) begin
          $display("ERROR: value exp %0d got %0d, count exp %0d got %0d, no_digits exp %0b got %0b",
                   exp_res.value, value, exp_res.count, count, exp_res.no_dig, no_dig);
        end
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   push;
  logic                   full;
  logic [CuW-1:0]         code_unit_i;
  logic                   last_unit_i;
  logic                   empty;
  logic                   pop;
  logic signed [ValW-1:0] value_o;
  logic [CountW-1:0]      consumed_count_o;
  logic                   no_digits_o;
  logic                   cfg_we_i;
  logic [RadixW-1:0]      cfg_wdata_i;

  conv_scoreboard sb;
  logic [CuW-1:0] text_q[$];
  int unsigned    units_sent;
  int unsigned    quiet_cycles;
  // These flags turn random idling on or off for the sender and the receiver.
  bit             tx_idle_on;
  bit             rx_idle_on;

  text_to_long_any_base_unit u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .code_unit_i      (code_unit_i),
    .last_unit_i      (last_unit_i),
    .empty            (empty),
    .pop              (pop),
    .value_o          (value_o),
    .consumed_count_o (consumed_count_o),
    .no_digits_o      (no_digits_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // This is the watchdog. The counter restarts at every input or result transaction.
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < QuietLimit) @(posedge clk_i);
    $display("text_to_long_any_base_unit regression: fail");
    $finish;
  end

  // This process is the result side. The outputs are sampled at the edge, before the DUT
  // updates them, so a transaction is exactly pop high and empty low at that edge.
  // When idling is on, pop then stalls in random bursts.
  initial begin
    int unsigned stall;
    pop   = 1'b0;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        sb.check_result(value_o, consumed_count_o, no_digits_o);
      end
      if (stall != 0) begin
        pop <= 1'b0;
        stall--;
      end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
        stall = $urandom_range(1, 4) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // This task sends one code unit and returns at the edge that accepts it. Push stays high
  // after that, so the caller must either push again or lower push in this same step.
  task automatic push_unit(input logic [CuW-1:0] cu, input logic lst);
    int unsigned gap;
    gap = 0;
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push        <= 1'b1;
    code_unit_i <= cu;
    last_unit_i <= lst;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sb.note_unit(cu, lst);
    units_sent++;
  endtask

  // This task sends the queued units as one string, with the last flag on the final unit.
  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) begin
      push_unit(text_q[i], i == text_q.size() - 1);
    end
    text_q.delete();
  endtask

  task automatic add_ascii(input string s);
    for (int i = 0; i < s.len(); i++) begin
      text_q = {text_q, {8'h00, 8'(s[i])}};
    end
  endtask

  task automatic send_ascii(input string s);
    add_ascii(s);
    send_text();
  endtask

  // This task waits until every expected result has been popped, then waits out the pipeline.
  task automatic settle();
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // The radix is written only when the block is idle, so it affects only the strings that follow.
  task automatic set_radix(input logic [RadixW-1:0] r);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= r;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.radix = r;
  endtask

  function automatic logic [CuW-1:0] digit_char(input int unsigned d);
    if (d < 10) return ChZero + CuW'(d);
    return ($urandom_range(0, 1) != 0) ? ChLowA + CuW'(d - 10) : ChUpA + CuW'(d - 10);
  endfunction

  function automatic logic [CuW-1:0] noise_unit();
    return ($urandom_range(0, 1) != 0) ? 16'($urandom) : 16'($urandom_range(0, 127));
  endfunction

  function automatic logic [RadixW-1:0] pick_radix();
    case ($urandom_range(0, 11))
      0:       return RadixAuto;
      1:       return 6'd1;
      2:       return 6'd2;
      3:       return BaseOct;
      4:       return BaseDec;
      5:       return BaseHex;
      6:       return 6'd36;
      7:       return 6'($urandom_range(37, 63));
      8:       return RadixAuto;
      9:       return BaseHex;
      default: return 6'($urandom_range(0, 36));
    endcase
  endfunction

  // Most random strings are well formed: whitespace, a sign, a prefix that fits the radix,
  // digits below the base, and trailing noise. Some are pure noise. Digit runs are sometimes
  // long enough to overflow.
  task automatic random_string();
    int unsigned n;
    int unsigned eff_base;
    int unsigned top;
    int unsigned mode;
    bit          dec_auto;
    dec_auto = 1'b0;
    if ($urandom_range(0, 99) < 15) begin
      repeat ($urandom_range(1, 6)) text_q = {text_q, noise_unit()};
    end else begin
      repeat ($urandom_range(0, 3)) begin
        text_q = {text_q, (($urandom_range(0, 1) != 0) ? ChSpace : 16'($urandom_range(9, 13)))};
      end
      case ($urandom_range(0, 2))
        1:       text_q = {text_q, ChPlus};
        2:       text_q = {text_q, ChMinus};
        default: begin
        end
      endcase
      eff_base = sb.radix;
      mode     = $urandom_range(0, 2);
      if (sb.radix == RadixAuto) begin
        if (mode == 0) begin
          text_q = {text_q, ChZero};
          text_q = {text_q, (($urandom_range(0, 1) != 0) ? ChLowX : ChUpX)};
          eff_base = 16;
        end else if (mode == 1) begin
          text_q = {text_q, ChZero};
          eff_base = 8;
        end else begin
          eff_base = 10;
          dec_auto = 1'b1;
        end
      end else if (sb.radix == BaseHex && mode == 0) begin
        text_q = {text_q, ChZero};
        text_q = {text_q, (($urandom_range(0, 1) != 0) ? ChLowX : ChUpX)};
      end
      top = (eff_base > 36) ? 36 : eff_base;
      case ($urandom_range(0, 9))
        0:       n = 0;
        1, 2:    n = $urandom_range(13, 70);
        default: n = $urandom_range(1, 12);
      endcase
      for (int i = 0; i < n; i++) begin
        if (dec_auto && i == 0) begin
          text_q = {text_q, digit_char($urandom_range(1, 9))};
        end else begin
          text_q = {text_q, digit_char($urandom_range(0, top - 1))};
        end
      end
      repeat ($urandom_range(0, 2)) text_q = {text_q, noise_unit()};
    end
    if (text_q.size() == 0) text_q = {text_q, noise_unit()};
    send_text();
  endtask

  initial begin
    int unsigned start_units;
    int unsigned strings;
    sb          = new();
    rst_ni      = 1'b0;
    push        = 1'b0;
    code_unit_i = '0;
    last_unit_i = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    units_sent  = 0;
    tx_idle_on  = 1'b1;
    rx_idle_on  = 1'b1;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // These strings run with the radix still at its reset value of ten. They cover the signed
    // limits, saturation on both sides, a full overflow, no digits, and whitespace of each kind.
    send_ascii("  -123");
    send_ascii("+9223372036854775807");
    send_ascii("-9223372036854775808");
    send_ascii("9223372036854775808");
    send_ascii("-9223372036854775809");
    send_ascii("18446744073709551616");
    send_ascii("+abc");
    send_ascii("-");
    text_q = {text_q, 16'h0000};
    send_text();
    text_q = {ChTab, 16'h000A, 16'h000B, 16'h000C, ChCr, ChSpace};
    add_ascii("42x7");
    send_text();
    // A zero unit ends the number. The digits after it are ignored.
    add_ascii("12");
    text_q = {text_q, 16'h0000};
    send_ascii("34");
    text_q = {16'hFFFF};
    send_text();
    text_q = {16'h0037, 16'hFFFF, 16'h0038};
    send_text();

    // The hex prefix is tried both bare and complete, with the most negative value and
    // with an overflow.
    set_radix(BaseHex);
    send_ascii("0x");
    send_ascii("0XfF");
    send_ascii("-0x8000000000000000");
    send_ascii("0x1ffffffffffffffff");
    send_ascii("0g");

    // With automatic detection, a leading zero selects octal and "0x" selects hex.
    set_radix(RadixAuto);
    send_ascii("0x1A");
    send_ascii("-017");
    send_ascii("09");
    send_ascii("123");
    send_ascii("-0X");

    // These are the unusual bases: radix one takes only zeros, and radix 63 takes every letter.
    set_radix(6'd1);
    send_ascii("00012");
    set_radix(6'd2);
    send_ascii("10112");
    set_radix(6'd36);
    send_ascii("zZ");
    send_ascii("-ZZZZZZZZZZZZZZ");
    set_radix(6'd63);
    send_ascii("zz9");
    set_radix(BaseOct);
    send_ascii("0x12");

    // The random part changes the radix every eight strings. In the final stretch both
    // sides stop idling, so the block runs at full rate.
    start_units = units_sent;
    strings     = 0;
    while (units_sent - start_units < UnitTarget) begin
      if (strings % 8 == 0) set_radix(pick_radix());
      if (units_sent - start_units > UnitTarget * 7 / 8) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end else begin
        tx_idle_on = $urandom_range(0, 2) != 0;
        rx_idle_on = $urandom_range(0, 2) != 0;
      end
      random_string();
      strings++;
    end

    settle();
    if (sb.failures == 0) begin
      $display("text_to_long_any_base_unit regression: pass");
    end else begin
      $display("text_to_long_any_base_unit regression: fail");
    end
    $finish;
  end

endmodule
